/* rtl/core/fas_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and structure types of the frame animation sequencer.
package fas_pkg;

   // Table size and field widths.
   localparam int MAX_FRAMES   = 256;
   localparam int FRAME_W      = 8;
   localparam int COUNT_W      = 9;
   localparam int OP_W         = 3;
   localparam int DELTA_W      = 24;
   localparam int UNITS_W      = 16;
   localparam int SPEED_W      = 16;
   localparam int UNIT_MS_W    = 10;
   localparam int Q_FRAC       = 8;

   // Time arithmetic widths in Q.8 milliseconds, except whole-ms durations and the step counter.
   localparam int ELAPSED_W    = 48;
   localparam int SUM_W        = ELAPSED_W + 1;
   localparam int PROD_W       = DELTA_W + SPEED_W;
   localparam int DUR_UNITS_W  = UNITS_W + UNIT_MS_W;
   localparam int DUR_W        = DUR_UNITS_W + Q_FRAC;
   localparam int LAP_W        = DUR_W + FRAME_W;
   localparam int TRIAL_W      = LAP_W + 1;
   localparam int DIV_CNT_W    = $clog2(ELAPSED_W);

   // Register port.
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = CSR_ADDR_W - 2;

   localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_FRAMES);
   localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(3);

   typedef enum logic [OP_W-1:0] {
      OP_TICK      = 3'd0,
      OP_STEP_FWD  = 3'd1,
      OP_STEP_BACK = 3'd2,
      OP_PLAY      = 3'd3,
      OP_PAUSE     = 3'd4,
      OP_LOAD      = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_COUNT = 3'd0,
      REG_LOOP_STEP   = 3'd1,
      REG_LOOPING     = 3'd2,
      REG_SPEED_Q8    = 3'd3,
      REG_UNIT_MS     = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   frame_count;
      logic [COUNT_W-1:0]   loop_step;
      logic                 looping;
      logic [SPEED_W-1:0]   speed_q8;
      logic [UNIT_MS_W-1:0] unit_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_count: '0,
      loop_step:   '0,
      looping:     1'b0,
      speed_q8:    SPEED_W'(256),
      unit_ms:     UNIT_MS_W'(20)
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic set_play;
      logic clr_play;
      logic ram_we;
      logic step_back;
      logic step_fwd;
      logic tick_mul;
      logic tick_add;
      logic dur_load;
      logic lap_sel;
      logic consume;
      logic lap_clear;
      logic lap_acc;
      logic div_init;
      logic div_step;
      logic rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   count_zero;
      logic   play;
      logic   dur_ge;
      logic   adv_ok;
      logic   looping;
      logic   reduced;
      logic   lap_last;
      logic   div_last;
   } dp_status_type;

endpackage

/* rtl/core/fas_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the frame animation sequencer.
interface fas_req_if;
   import fas_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [DELTA_W-1:0]   delta_ms;
   logic [FRAME_W-1:0]   frame_address;
   logic [UNITS_W-1:0]   sequence_units;
   logic [UNITS_W-1:0]   fallback_units;
   logic                 restart_now;

   modport source (output valid, operation, delta_ms, frame_address, sequence_units,
                   fallback_units, restart_now, input ready);
   modport sink (input valid, operation, delta_ms, frame_address, sequence_units,
                 fallback_units, restart_now, output ready);
endinterface

interface fas_rsp_if;
   import fas_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 frame_changed;
   logic [FRAME_W-1:0]   frame_index;
   logic                 playing;

   modport source (output valid, frame_changed, frame_index, playing, input ready);
   modport sink (input valid, frame_changed, frame_index, playing, output ready);
endinterface

/* rtl/core/frame_animation_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the frame animation sequencer.
//
//   Channel   Direction  Handshake         Carries
//   req_bus   in         valid/ready       operation, delta, table load, restart
//   rsp_bus   out        valid/ready       frame_changed, frame_index, playing
//   APB       in/out     psel/penable      five configuration registers
//
// Play, pause, load, steps, spare codes and a paused or frameless tick go from dispatch
// straight to the response. A playing tick adds multiply and add, then a read, multiply and
// compare per frame; the first wrap adds the lap sum over the loop and the remainder.
// Reset is synchronous; the duration table is not cleared and needs no sweep.
// Input items are taken while a finished response still waits on rsp_bus; the next
// item then holds in its last cycle until the receiver has taken the waiting one.
module frame_animation_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   fas_req_if.sink                         req_bus,
   fas_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fas_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fas_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fas_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import fas_pkg::*;

   // Configuration is held in the register file and read live by the datapath; the user
   // must write it only while the block is idle, which the block itself does not enforce.
   cfg_type       cfg;

   // The controller and the datapath talk only through these two bundles.
   dp_cmd_type    cmd;
   dp_status_type status;

   logic          req_ready;
   logic          rsp_valid;

   fas_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller walks each item through dispatch and, for a playing tick, the tick multiply
   // and add, the per-frame read/multiply/compare loop, the lap sum and the remainder.
   fas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath captures the item at acceptance and owns all frame state,
   // the duration table and the response register.
   fas_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .operation      (req_bus.operation),
      .delta_ms       (req_bus.delta_ms),
      .frame_address  (req_bus.frame_address),
      .sequence_units (req_bus.sequence_units),
      .fallback_units (req_bus.fallback_units),
      .restart_now    (req_bus.restart_now),
      .frame_changed  (rsp_bus.frame_changed),
      .frame_index    (rsp_bus.frame_index),
      .playing        (rsp_bus.playing)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
endmodule

/* rtl/core/fas_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fas_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/fas_regs.sv */
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module fas_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fas_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fas_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fas_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output fas_pkg::cfg_type                cfg
);
   import fas_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_FRAME_COUNT: cfg_in.frame_count = pwdata[COUNT_W-1:0];
            REG_LOOP_STEP:   cfg_in.loop_step   = pwdata[COUNT_W-1:0];
            REG_LOOPING:     cfg_in.looping     = pwdata[0];
            REG_SPEED_Q8:    cfg_in.speed_q8    = pwdata[SPEED_W-1:0];
            REG_UNIT_MS:     cfg_in.unit_ms     = pwdata[UNIT_MS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FRAME_COUNT: prdata = CSR_DATA_W'(cfg_ff.frame_count);
         REG_LOOP_STEP:   prdata = CSR_DATA_W'(cfg_ff.loop_step);
         REG_LOOPING:     prdata = CSR_DATA_W'(cfg_ff.looping);
         REG_SPEED_Q8:    prdata = CSR_DATA_W'(cfg_ff.speed_q8);
         REG_UNIT_MS:     prdata = CSR_DATA_W'(cfg_ff.unit_ms);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* rtl/core/fas_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the frame animation sequencer.
module fas_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fas_pkg::dp_status_type status,
   output fas_pkg::dp_cmd_type    cmd
);
   import fas_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_DISPATCH = 12'b0000_0000_0010,
      S_TMUL     = 12'b0000_0000_0100,
      S_TADD     = 12'b0000_0000_1000,
      S_FADDR    = 12'b0000_0001_0000,
      S_FMUL     = 12'b0000_0010_0000,
      S_FCMP     = 12'b0000_0100_0000,
      S_LADDR    = 12'b0000_1000_0000,
      S_LMUL     = 12'b0001_0000_0000,
      S_LACC     = 12'b0010_0000_0000,
      S_DIV      = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            unique case (status.op)
               OP_TICK: begin
                  if (status.play && !status.count_zero) begin
                     state_in = S_TMUL;
                  end
               end
               OP_STEP_FWD:  cmd.step_fwd  = !status.count_zero;
               OP_STEP_BACK: cmd.step_back = !status.count_zero;
               OP_PLAY:      cmd.set_play  = 1'b1;
               OP_PAUSE:     cmd.clr_play  = 1'b1;
               OP_LOAD:      cmd.ram_we    = 1'b1;
               default:      state_in      = S_DONE;
            endcase
         end
         S_TMUL: begin
            cmd.tick_mul = 1'b1;
            state_in     = S_TADD;
         end
         S_TADD: begin
            cmd.tick_add = 1'b1;
            state_in     = S_FADDR;
         end
         S_FADDR: begin
            state_in = S_FMUL;
         end
         S_FMUL: begin
            cmd.dur_load = 1'b1;
            state_in     = S_FCMP;
         end
         S_FCMP: begin
            if (!status.dur_ge) begin
               state_in = S_DONE;
            end else begin
               cmd.consume = 1'b1;
               priority if (status.adv_ok) begin
                  state_in = S_FADDR;
               end else if (!status.looping) begin
                  state_in = S_DONE;
               end else if (!status.reduced) begin
                  cmd.lap_clear = 1'b1;
                  state_in      = S_LADDR;
               end else begin
                  state_in = S_FADDR;
               end
            end
         end
         S_LADDR: begin
            cmd.lap_sel = 1'b1;
            state_in    = S_LMUL;
         end
         S_LMUL: begin
            cmd.lap_sel  = 1'b1;
            cmd.dur_load = 1'b1;
            state_in     = S_LACC;
         end
         S_LACC: begin
            cmd.lap_acc = 1'b1;
            if (status.lap_last) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_LADDR;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FADDR;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted item did not move to dispatch");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");
`endif
endmodule

/* rtl/core/fas_dp.sv */
`timescale 1ns / 1ps
// Datapath: frame state, duration table, tick arithmetic, lap sum and remainder unit.
module fas_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  fas_pkg::cfg_type                cfg,
   input  fas_pkg::dp_cmd_type             cmd,
   output fas_pkg::dp_status_type          status,
   input  logic [fas_pkg::OP_W-1:0]        operation,
   input  logic [fas_pkg::DELTA_W-1:0]     delta_ms,
   input  logic [fas_pkg::FRAME_W-1:0]     frame_address,
   input  logic [fas_pkg::UNITS_W-1:0]     sequence_units,
   input  logic [fas_pkg::UNITS_W-1:0]     fallback_units,
   input  logic                            restart_now,
   output logic                            frame_changed,
   output logic [fas_pkg::FRAME_W-1:0]     frame_index,
   output logic                            playing
);
   import fas_pkg::*;

   // Effective configuration and advance logic.
   logic [COUNT_W-1:0]     count;
   logic [COUNT_W-1:0]     next_frame;
   logic [FRAME_W-1:0]     loop_start, last_frame, adv_frame;
   logic                   adv_ok, adv_ret, stop, in_range;
   logic [SPEED_W-1:0]     speed_eff;
   logic [UNIT_MS_W-1:0]   unit_eff;
   logic [UNITS_W-1:0]     rdata, units_sel;
   logic [DUR_UNITS_W-1:0] dur_units;
   logic [SUM_W-1:0]       tick_sum;
   logic [TRIAL_W-1:0]     div_trial, div_diff;
   logic [LAP_W-1:0]       rem_next;
   logic [FRAME_W-1:0]     raddr;
   logic                   div_last;
   logic                   ram_we;

   // Registers.
   logic [OP_W-1:0]        op_ff, op_in;
   logic [DELTA_W-1:0]     delta_ff, delta_in;
   logic [FRAME_W-1:0]     addr_ff, addr_in;
   logic [UNITS_W-1:0]     load_units_ff, load_units_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic                   play_ff, play_in;
   logic                   changed_ff, changed_in;
   logic                   reduced_ff, reduced_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [DUR_W-1:0]       dur_ff, dur_in;
   logic [LAP_W-1:0]       lap_ff, lap_in;
   logic [FRAME_W-1:0]     lidx_ff, lidx_in;
   logic [LAP_W-1:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic                   rsp_play_ff, rsp_play_in;

   assign count      = (cfg.frame_count > MAX_COUNT) ? MAX_COUNT : cfg.frame_count;
   assign loop_start = (cfg.loop_step != '0 && cfg.loop_step <= count) ?
                       FRAME_W'(count - cfg.loop_step) : '0;
   assign last_frame = FRAME_W'(count - COUNT_W'(1));
   assign next_frame = COUNT_W'(frame_ff) + COUNT_W'(1);
   assign adv_ok     = next_frame < count;
   assign adv_ret    = adv_ok || cfg.looping;
   assign stop       = !adv_ret;
   assign adv_frame  = adv_ok ? next_frame[FRAME_W-1:0] :
                       (cfg.looping ? loop_start : last_frame);
   assign speed_eff  = (cfg.speed_q8 < SPEED_MIN) ? SPEED_MIN : cfg.speed_q8;
   assign unit_eff   = (cfg.unit_ms == '0) ? UNIT_MS_W'(1) : cfg.unit_ms;

   // A frame past the count, or a zero entry, lasts one unit.
   assign in_range  = cmd.lap_sel || (COUNT_W'(frame_ff) < count);
   assign units_sel = (!in_range || rdata == '0) ? UNITS_W'(1) : rdata;
   assign dur_units = DUR_UNITS_W'(units_sel) * DUR_UNITS_W'(unit_eff);

   assign tick_sum  = SUM_W'(elapsed_ff) + SUM_W'(prod_ff);

   // One restoring remainder step per cycle, most significant bit first.
   assign div_trial = {rem_ff, elapsed_ff[ELAPSED_W-1]};
   assign div_diff  = div_trial - TRIAL_W'(lap_ff);
   assign rem_next  = (div_trial >= TRIAL_W'(lap_ff)) ? div_diff[LAP_W-1:0] :
                      div_trial[LAP_W-1:0];
   assign div_last  = (div_cnt_ff == DIV_CNT_W'(ELAPSED_W - 1));

   assign raddr  = cmd.lap_sel ? lidx_ff : frame_ff;
   assign ram_we = cmd.ram_we && (COUNT_W'(addr_ff) < MAX_COUNT);

   fas_ram #(
      .DATA_W (UNITS_W),
      .DEPTH  (MAX_FRAMES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (load_units_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      op_in          = op_ff;
      delta_in       = delta_ff;
      addr_in        = addr_ff;
      load_units_in  = load_units_ff;
      frame_in       = frame_ff;
      elapsed_in     = elapsed_ff;
      play_in        = play_ff;
      changed_in     = changed_ff;
      reduced_in     = reduced_ff;
      prod_in        = prod_ff;
      dur_in         = dur_ff;
      lap_in         = lap_ff;
      lidx_in        = lidx_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_play_in    = rsp_play_ff;

      if (cmd.latch) begin
         op_in      = operation;
         delta_in   = delta_ms;
         addr_in    = frame_address;
         changed_in = 1'b0;
         reduced_in = 1'b0;
         if (sequence_units != '0) begin
            load_units_in = sequence_units;
         end else if (fallback_units != '0) begin
            load_units_in = fallback_units;
         end else begin
            load_units_in = UNITS_W'(1);
         end
         if (restart_now) begin
            frame_in   = '0;
            elapsed_in = '0;
         end
      end

      if (cmd.set_play) begin
         play_in = 1'b1;
      end
      if (cmd.clr_play) begin
         play_in = 1'b0;
      end

      if (cmd.step_back) begin
         frame_in   = (frame_ff != '0) ? frame_ff - FRAME_W'(1) : last_frame;
         elapsed_in = '0;
         changed_in = 1'b1;
      end

      if (cmd.step_fwd) begin
         frame_in   = adv_frame;
         elapsed_in = '0;
         changed_in = adv_ret;
         if (stop) begin
            play_in = 1'b0;
         end
      end

      if (cmd.tick_mul) begin
         prod_in = PROD_W'(delta_ff) * PROD_W'(speed_eff);
      end
      if (cmd.tick_add) begin
         elapsed_in = tick_sum[ELAPSED_W] ? '1 : tick_sum[ELAPSED_W-1:0];
      end

      if (cmd.dur_load) begin
         dur_in = {dur_units, {Q_FRAC{1'b0}}};
      end

      if (cmd.consume) begin
         frame_in = adv_frame;
         if (stop) begin
            elapsed_in = '0;
            play_in    = 1'b0;
         end else begin
            elapsed_in = elapsed_ff - ELAPSED_W'(dur_ff);
            changed_in = 1'b1;
         end
      end

      if (cmd.lap_clear) begin
         lap_in  = '0;
         lidx_in = loop_start;
      end
      if (cmd.lap_acc) begin
         lap_in  = lap_ff + LAP_W'(dur_ff);
         lidx_in = lidx_ff + FRAME_W'(1);
      end

      if (cmd.div_init) begin
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in     = rem_next;
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (div_last) begin
            elapsed_in = ELAPSED_W'(rem_next);
            reduced_in = 1'b1;
         end else begin
            elapsed_in = {elapsed_ff[ELAPSED_W-2:0], 1'b0};
         end
      end

      if (cmd.rsp_load) begin
         rsp_changed_in = changed_ff;
         rsp_frame_in   = frame_ff;
         rsp_play_in    = play_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         elapsed_ff <= '0;
         play_ff    <= 1'b0;
         changed_ff <= 1'b0;
         reduced_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         frame_ff   <= frame_in;
         elapsed_ff <= elapsed_in;
         play_ff    <= play_in;
         changed_ff <= changed_in;
         reduced_ff <= reduced_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      delta_ff       <= delta_in;
      addr_ff        <= addr_in;
      load_units_ff  <= load_units_in;
      prod_ff        <= prod_in;
      dur_ff         <= dur_in;
      lap_ff         <= lap_in;
      lidx_ff        <= lidx_in;
      rem_ff         <= rem_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_play_ff    <= rsp_play_in;
   end

   assign status.op         = op_type'(op_ff);
   assign status.count_zero = (count == '0);
   assign status.play       = play_ff;
   assign status.dur_ge     = (elapsed_ff >= ELAPSED_W'(dur_ff));
   assign status.adv_ok     = adv_ok;
   assign status.looping    = cfg.looping;
   assign status.reduced    = reduced_ff;
   assign status.lap_last   = (lidx_ff == last_frame);
   assign status.div_last   = div_last;

   assign frame_changed = rsp_changed_ff;
   assign frame_index   = rsp_frame_ff;
   assign playing       = rsp_play_ff;

`ifndef SYNTH
   a_rem_below_lap: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && div_last) |=> (elapsed_ff < ELAPSED_W'(lap_ff)))
      else $error("reduced elapsed time is not below the lap length");

   a_stop_at_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.consume && stop) |=> (!play_ff && elapsed_ff == '0 && frame_ff == last_frame))
      else $error("stop at end did not park on the last frame");
`endif
endmodule

/* dv/frame_animation_sequencer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the frame animation sequencer with its frame timing predictor.
module frame_animation_sequencer_tb;
   import fas_pkg::*;

   // Spare operation codes that the block has to accept and ignore.
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   // The slowest legal tick checks up to two passes over 256 frames plus the remainder
   // step. The limit covers every item at the cost of that slowest tick several times over.
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS = 20;
   localparam logic [63:0] ELAPSED_CAP = (64'd1 << ELAPSED_W) - 64'd1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [DELTA_W-1:0] delta;
      logic [FRAME_W-1:0] addr;
      logic [UNITS_W-1:0] seq;
      logic [UNITS_W-1:0] fb;
      logic               restart;
   } anim_req_type;

   typedef struct packed {
      logic               frame_changed;
      logic [FRAME_W-1:0] frame_index;
      logic               playing;
   } anim_rsp_type;

   // The scoreboard keeps its own copy of the sequencer state and the registers. Each
   // accepted item is run through that copy at once, and the outcome waits in a queue
   // until the matching result leaves the block.
   class anim_scoreboard;
      logic [UNITS_W-1:0] dur_units [MAX_FRAMES];
      logic [FRAME_W-1:0] cur_frame;
      logic [63:0]        elapsed_q8;
      logic               play_on;
      cfg_type            cfg;
      anim_rsp_type       frame_q [$];
      int                 errors;
      int                 checked;
      int                 changes;

      function new();
         foreach (dur_units[i]) dur_units[i] = '0;
         cur_frame  = '0;
         elapsed_q8 = '0;
         play_on    = 1'b0;
         cfg        = CFG_RESET;
         errors     = 0;
         checked    = 0;
         changes    = 0;
      endfunction

      function int pending();
         return frame_q.size();
      endfunction

      function void write_reg(reg_idx_type idx, logic [31:0] value);
         case (idx)
            REG_FRAME_COUNT: cfg.frame_count = value[COUNT_W-1:0];
            REG_LOOP_STEP:   cfg.loop_step   = value[COUNT_W-1:0];
            REG_LOOPING:     cfg.looping     = value[0];
            REG_SPEED_Q8:    cfg.speed_q8    = value[SPEED_W-1:0];
            REG_UNIT_MS:     cfg.unit_ms     = value[UNIT_MS_W-1:0];
            default: ;
         endcase
      endfunction

      // A frame count above the table size acts as the table size.
      function int unsigned live_count();
         int unsigned c;
         c = cfg.frame_count;
         if (c > MAX_FRAMES) c = MAX_FRAMES;
         return c;
      endfunction

      function int unsigned loop_origin(int unsigned count);
         if (cfg.loop_step != 0 && cfg.loop_step <= count) return count - cfg.loop_step;
         return 0;
      endfunction

      // Frame length in Q.8 milliseconds; a frame beyond the count lasts one unit.
      function logic [63:0] frame_len(int unsigned idx, int unsigned count);
         logic [63:0] units;
         logic [63:0] per_unit;
         units    = 64'd1;
         per_unit = (cfg.unit_ms != 0) ? 64'(cfg.unit_ms) : 64'd1;
         if (idx < count) begin
            units = 64'(dur_units[idx]);
            if (units == 0) units = 64'd1;
         end
         return (units * per_unit) << Q_FRAC;
      endfunction

      // Moves one frame on. Returns 0 when a non-looping sequence stops on its last frame.
      function bit move_on(int unsigned count, output bit wrapped);
         int unsigned nxt;
         nxt     = cur_frame + 1;
         wrapped = 1'b0;
         if (nxt < count) begin
            cur_frame = FRAME_W'(nxt);
            return 1'b1;
         end
         if (!cfg.looping) begin
            cur_frame = FRAME_W'(count - 1);
            play_on   = 1'b0;
            return 1'b0;
         end
         cur_frame = FRAME_W'(loop_origin(count));
         wrapped   = 1'b1;
         return 1'b1;
      endfunction

      function bit run_tick(logic [DELTA_W-1:0] delta);
         int unsigned count;
         int unsigned i;
         logic [63:0] sp;
         logic [63:0] sum;
         logic [63:0] d;
         logic [63:0] lap;
         bit          moved;
         bit          reduced;
         bit          wrapped;
         count   = live_count();
         sp      = (cfg.speed_q8 < SPEED_MIN) ? 64'(SPEED_MIN) : 64'(cfg.speed_q8);
         moved   = 1'b0;
         reduced = 1'b0;
         if (!play_on || count == 0) return 1'b0;
         sum        = elapsed_q8 + 64'(delta) * sp;
         elapsed_q8 = (sum > ELAPSED_CAP) ? ELAPSED_CAP : sum;
         while (play_on) begin
            d = frame_len(cur_frame, count);
            if (elapsed_q8 < d) break;
            elapsed_q8 = elapsed_q8 - d;
            if (!move_on(count, wrapped)) begin
               elapsed_q8 = '0;
               break;
            end
            moved = 1'b1;
            // After the first wrap, whole laps of the loop are dropped in one go.
            if (wrapped && !reduced) begin
               lap = '0;
               for (i = loop_origin(count); i < count; i++) lap = lap + frame_len(i, count);
               elapsed_q8 = elapsed_q8 % lap;
               reduced    = 1'b1;
            end
         end
         return moved;
      endfunction

      function void note_item(anim_req_type r);
         int unsigned        count;
         bit                 moved;
         bit                 wrapped;
         logic [UNITS_W-1:0] units;
         anim_rsp_type       want;
         count = live_count();
         moved = 1'b0;
         if (r.restart) begin
            cur_frame  = '0;
            elapsed_q8 = '0;
         end
         case (r.op)
            OP_TICK: moved = run_tick(r.delta);
            OP_STEP_FWD: begin
               if (count != 0) begin
                  elapsed_q8 = '0;
                  moved      = move_on(count, wrapped);
               end
            end
            OP_STEP_BACK: begin
               if (count != 0) begin
                  if (cur_frame > 0) cur_frame = cur_frame - 1'b1;
                  else cur_frame = FRAME_W'(count - 1);
                  elapsed_q8 = '0;
                  moved      = 1'b1;
               end
            end
            OP_PLAY:  play_on = 1'b1;
            OP_PAUSE: play_on = 1'b0;
            OP_LOAD: begin
               units = (r.seq != 0) ? r.seq : r.fb;
               if (units == 0) units = 1;
               dur_units[r.addr] = units;
            end
            default: ;
         endcase
         want.frame_changed = moved;
         want.frame_index   = cur_frame;
         want.playing       = play_on;
         frame_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch on result %0d, expected %0d, actual %0d",
                        $time, name, checked, want, got);
         end
      endfunction

      function void check_result(anim_rsp_type got);
         anim_rsp_type want;
         if (frame_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with no item waiting, expected none, actual %0d/%0d/%0d",
                        $time, got.frame_changed, got.frame_index, got.playing);
            return;
         end
         want = frame_q.pop_front();
         checked++;
         if (got.frame_changed === 1'b1) changes++;
         compare_field("frame_changed", 8'(want.frame_changed), 8'(got.frame_changed));
         compare_field("frame_index", want.frame_index, got.frame_index);
         compare_field("playing", 8'(want.playing), 8'(got.playing));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fas_req_if req_bus ();
   fas_rsp_if rsp_bus ();

   anim_scoreboard sb;

   // Table entries that some load has written; a tick must never read any other entry.
   bit entry_loaded [MAX_FRAMES];
   int items_sent;
   int settings_count;
   int burst_left;
   bit steady_sender;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit long_hold_req;

   frame_animation_sequencer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("frame_animation_sequencer_tb NOT OK");
      $finish;
   end

   // Both channels are sampled at the rising edge, before any of this edge's updates land,
   // so the monitor sees exactly the values at which the handshakes happen. A result always
   // trails its item, so checking before noting is safe.
   always @(posedge clock) begin
      anim_rsp_type seen;
      anim_req_type taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.frame_changed = rsp_bus.frame_changed;
            seen.frame_index   = rsp_bus.frame_index;
            seen.playing       = rsp_bus.playing;
            sb.check_result(seen);
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.op      = req_bus.operation;
            taken.delta   = req_bus.delta_ms;
            taken.addr    = req_bus.frame_address;
            taken.seq     = req_bus.sequence_units;
            taken.fb      = req_bus.fallback_units;
            taken.restart = req_bus.restart_now;
            sb.note_item(taken);
         end
      end
   end

   // The receiver switches between levels of willingness, from always ready down to
   // rarely ready. On request it holds off for a long stretch so that a finished result
   // waits, the block fills up and the sender sees its input stall.
   initial begin
      int pct;
      int mode_left;
      pct = 100;
      mode_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end
         if (mode_left <= 0) begin
            case ($urandom_range(0, 3))
               0: pct = 100;
               1: pct = 80;
               2: pct = 50;
               default: pct = 20;
            endcase
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         rsp_bus.ready <= ($urandom_range(0, 99) < pct);
      end
   end

   function automatic anim_req_type make_req(logic [OP_W-1:0] op,
                                             logic [DELTA_W-1:0] delta = '0,
                                             logic [FRAME_W-1:0] addr = '0,
                                             logic [UNITS_W-1:0] seq = '0,
                                             logic [UNITS_W-1:0] fb = '0,
                                             logic restart = 1'b0);
      anim_req_type r;
      r.op      = op;
      r.delta   = delta;
      r.addr    = addr;
      r.seq     = seq;
      r.fb      = fb;
      r.restart = restart;
      return r;
   endfunction

   // Mostly ticks of display-rate size, with steps, play and pause, loads of new durations,
   // the odd restart and the spare codes as noise. Unused fields carry random content.
   function automatic anim_req_type random_item();
      anim_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) r.op = OP_TICK;
      else if (pick < 60) r.op = OP_STEP_FWD;
      else if (pick < 68) r.op = OP_STEP_BACK;
      else if (pick < 76) r.op = OP_PLAY;
      else if (pick < 82) r.op = OP_PAUSE;
      else if (pick < 96) r.op = OP_LOAD;
      else r.op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      pick = $urandom_range(0, 9);
      if (pick < 7) r.delta = DELTA_W'($urandom_range(0, 200));
      else if (pick < 9) r.delta = DELTA_W'($urandom_range(0, 20000));
      else r.delta = DELTA_W'($urandom());
      r.addr = FRAME_W'($urandom());
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         r.seq = UNITS_W'($urandom_range(0, 8));
         r.fb  = UNITS_W'($urandom_range(0, 8));
      end else if (pick < 7) begin
         r.seq = '0;
         r.fb  = '0;
      end else if (pick < 9) begin
         r.seq = UNITS_W'($urandom_range(0, 255));
         r.fb  = UNITS_W'($urandom_range(0, 255));
      end else begin
         r.seq = UNITS_W'($urandom());
         r.fb  = UNITS_W'($urandom());
      end
      r.restart = ($urandom_range(0, 99) < 6);
      return r;
   endfunction

   // Inserts a random gap when a burst runs out, unless this setting sends back to back.
   task automatic pace();
      if (steady_sender) return;
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // Offers one item and returns at the edge that accepts it. A following item keeps valid
   // high, so valid is only lowered in pace and settle and never in the step that raises it.
   task automatic send_item(anim_req_type r);
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= r.op;
      req_bus.delta_ms       <= r.delta;
      req_bus.frame_address  <= r.addr;
      req_bus.sequence_units <= r.seq;
      req_bus.fallback_units <= r.fb;
      req_bus.restart_now    <= r.restart;
      if (r.op == OP_LOAD) entry_loaded[r.addr] = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      pace();
   endtask

   // Stops offering and waits until every outstanding result has been checked.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(int count, int lstep, bit loop_on, int speed, int unit);
      settle();
      csr_write(REG_FRAME_COUNT, 32'(count));
      csr_write(REG_LOOP_STEP, 32'(lstep));
      csr_write(REG_LOOPING, 32'(loop_on));
      csr_write(REG_SPEED_Q8, 32'(speed));
      csr_write(REG_UNIT_MS, 32'(unit));
      settings_count++;
      steady_sender = ($urandom_range(0, 3) == 0);
      burst_left    = $urandom_range(1, 16);
   endtask

   // Loads every entry inside the frame count that no earlier load has written.
   task automatic fill_table(int count);
      int i;
      if (count > MAX_FRAMES) count = MAX_FRAMES;
      for (i = 0; i < count; i++)
         if (!entry_loaded[i])
            send_item(make_req(OP_LOAD, '0, FRAME_W'(i), UNITS_W'($urandom_range(0, 8)),
                               UNITS_W'($urandom_range(0, 8))));
   endtask

   task automatic run_phase(int count, int lstep, bit loop_on, int speed, int unit,
                            int n_items, bit hold);
      int i;
      apply_settings(count, lstep, loop_on, speed, unit);
      fill_table(count);
      if (hold) long_hold_req = 1'b1;
      send_item(make_req(OP_PLAY));
      for (i = 0; i < n_items; i++) send_item(random_item());
   endtask

   initial begin
      int k;
      sb = new();
      items_sent     = 0;
      settings_count = 0;
      burst_left     = 4;
      steady_sender  = 1'b0;
      long_hold_req  = 1'b0;
      foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;
      reset                  <= 1'b1;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= OP_TICK;
      req_bus.delta_ms       <= '0;
      req_bus.frame_address  <= '0;
      req_bus.sequence_units <= '0;
      req_bus.fallback_units <= '0;
      req_bus.restart_now    <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With no frames loaded, a paused tick, a playing tick and both steps
      // must all leave the frame alone, and the spare codes must change nothing.
      send_item(make_req(OP_TICK, '1));
      send_item(make_req(OP_PLAY));
      send_item(make_req(OP_TICK, DELTA_W'(1000)));
      send_item(make_req(OP_STEP_FWD));
      send_item(make_req(OP_STEP_BACK));
      send_item(make_req(OP_SPARE_6, '1, '1, '1, '1, 1'b0));
      send_item(make_req(OP_SPARE_7, '1, '1, '1, '1, 1'b1));
      // Loads that fall back from a zero sequence duration to the frame delay and then to
      // one unit, plus the widest duration and the highest address.
      send_item(make_req(OP_LOAD, '0, FRAME_W'(0), '0, '0));
      send_item(make_req(OP_LOAD, '0, FRAME_W'(1), '0, UNITS_W'(3)));
      send_item(make_req(OP_LOAD, '0, FRAME_W'(2), UNITS_W'(2), UNITS_W'(7)));
      send_item(make_req(OP_LOAD, '0, FRAME_W'(3), '1, '0));
      send_item(make_req(OP_LOAD, '0, '1, '0, '1));

      // Four frames looping back to frame 2: a single-frame advance, a maximum tick that
      // wraps and drops whole laps, a paused tick, a restart then a step back from frame 0
      // that wraps to the last frame, and a step forward that wraps.
      apply_settings(4, 2, 1'b1, 256, 1);
      send_item(make_req(OP_PLAY));
      send_item(make_req(OP_TICK, DELTA_W'(1)));
      send_item(make_req(OP_TICK, '1));
      send_item(make_req(OP_PAUSE));
      send_item(make_req(OP_TICK, DELTA_W'(500)));
      send_item(make_req(OP_STEP_BACK, '0, '0, '0, '0, 1'b1));
      send_item(make_req(OP_STEP_FWD));
      send_item(make_req(OP_PLAY));

      // Without looping, a long tick stops on the last frame and clears play; a step
      // forward from there reports no change.
      apply_settings(4, 2, 1'b0, 256, 1);
      send_item(make_req(OP_TICK, '1));
      send_item(make_req(OP_STEP_FWD));

      // The count shrinks below the current frame: that frame lasts one unit and advancing
      // from it lands on the new last frame.
      apply_settings(2, 0, 1'b0, 256, 1);
      send_item(make_req(OP_PLAY));
      send_item(make_req(OP_TICK, DELTA_W'(10)));
      send_item(make_req(OP_STEP_FWD, '0, '0, '0, '0, 1'b1));

      // Random part over a spread of settings: loop start inside, at and beyond the count,
      // speeds below the minimum and at the top, unit of zero and the widest unit, a single
      // frame, the full table, a count above the table size and no frames at all. The
      // second setting also carries the long receiver hold-off.
      run_phase(8, 3, 1'b1, 256, 20, 130, 1'b0);
      run_phase(5, 0, 1'b1, 512, 1, 130, 1'b1);
      run_phase(16, 16, 1'b1, 65535, 1, 120, 1'b0);
      run_phase(3, 9, 1'b1, 0, 0, 120, 1'b0);
      run_phase(12, 4, 1'b0, 2, 1023, 100, 1'b0);
      run_phase(1, 1, 1'b1, 3, 1, 100, 1'b0);
      run_phase(256, 256, 1'b1, 300, 1, 40, 1'b0);
      run_phase(511, 100, 1'b1, 128, 2, 40, 1'b0);
      run_phase(256, 0, 1'b0, 256, 5, 30, 1'b0);
      run_phase(0, 0, 1'b1, 256, 20, 30, 1'b0);
      for (k = 0; k < 5; k++)
         run_phase($urandom_range(1, 24), $urandom_range(0, 30), 1'(($urandom_range(0, 1))),
                   $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(64, 1024),
                   $urandom_range(0, 1) ? $urandom_range(1, 50) : $urandom_range(0, 1023),
                   130, 1'b0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items under %0d register settings; %0d results checked, %0d moved.",
               items_sent, settings_count, sb.checked, sb.changes);
      $display("Included one %0d-cycle receiver hold-off; %0d mismatches found.",
               HOLD_CYCLES, sb.errors);
      if (sb.errors == 0) begin
         $display("frame_animation_sequencer_tb OK");
      end else begin
         $display("frame_animation_sequencer_tb NOT OK");
      end
      $finish;
   end

endmodule
